### hdl/okvl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okvl_pkg
// Shared types and codes for the ordered key/value list.
// ----------------------------------------------------------------------------
package okvl_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic [2:0] CMD_INS_FRONT = 3'd0;
	localparam logic [2:0] CMD_INS_BACK  = 3'd1;
	localparam logic [2:0] CMD_REM_FRONT = 3'd2;
	localparam logic [2:0] CMD_REM_BACK  = 3'd3;
	localparam logic [2:0] CMD_REM_AT    = 3'd4;
	localparam logic [2:0] CMD_SEARCH    = 3'd5;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_BACK,
		OP_REM_FRONT,
		OP_REM_BACK,
		OP_REM_AT,
		OP_SEARCH,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic        [2:0]  cmd;
		logic signed [31:0] key_in;
		logic signed [31:0] value_in;
		logic        [5:0]  position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed_key;
		logic        [5:0]  found_index;
		logic signed [31:0] found_value;
		logic        [6:0]  count_out;
	} rsp_t;

	// decoded command handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [31:0] value;
		logic [5:0]  position;
	} job_t;

	localparam rsp_t RSP_ZERO = '{
		status: ST_OK,
		removed_key: 32'sd0,
		found_index: 6'd0,
		found_value: 32'sd0,
		count_out: 7'd0
	};

endpackage
`default_nettype wire

### hdl/okvl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okvl_front
// Accepts command items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module okvl_front import okvl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      job_valid,
	output job_t      job,
	input  wire logic take
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       accept;
	job_t       dec;

	always_comb begin
		dec.key      = req.key_in;
		dec.value    = req.value_in;
		dec.position = req.position;
		unique case (req.cmd)
			CMD_INS_FRONT: dec.op = OP_INS_FRONT;
			CMD_INS_BACK:  dec.op = OP_INS_BACK;
			CMD_REM_FRONT: dec.op = OP_REM_FRONT;
			CMD_REM_BACK:  dec.op = OP_REM_BACK;
			CMD_REM_AT:    dec.op = OP_REM_AT;
			CMD_SEARCH:    dec.op = OP_SEARCH;
			default:       dec.op = OP_NOP;
		endcase
	end

	assign full      = (fill_q == 2'd2);
	assign accept    = push && !full;
	assign job_valid = (fill_q != 2'd0);
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, accept} - {1'b0, take};
		end
	end

endmodule
`default_nettype wire

### hdl/okvl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okvl_back
// Executes decoded commands on a circular key/value store and holds the
// result item until it is popped.
// ----------------------------------------------------------------------------
module okvl_back import okvl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire job_t job,
	output logic      take,
	output logic      empty,
	input  wire logic pop,
	output rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 6) ? CW : 6;
	localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_SEARCH,
		S_SHRD,
		S_SHWR
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   idx_q;
	job_t            cur_q;
	rsp_t            res_q;
	logic            res_valid_q;
	rsp_t            out_q;
	logic            out_valid_q;
	logic [63:0]     mem_q [DEPTH];
	logic [63:0]     rd_data_q;

	logic            start;
	logic            xfer;
	logic            is_full;
	logic            is_empty;
	logic            bad_pos;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   head_dec;
	logic [AW-1:0]   rd_lidx;
	logic [AW-1:0]   rd_addr;
	logic            we;
	logic [AW-1:0]   wa;
	logic [63:0]     wd;
	logic [AW-1:0]   cur_pos;
	rsp_t            start_rsp;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
	                                       input logic [AW-1:0] lidx);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, lidx};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[AW-1:0];
	endfunction

	assign start    = job_valid && (state_q == S_IDLE) && !res_valid_q;
	assign take     = start;
	// finished result moves to the output register once that one is free
	assign xfer     = res_valid_q && (!out_valid_q || pop);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign bad_pos  = (PW'(job.position) >= PW'(count_q));
	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST : head_q - 1'b1;
	assign cur_pos  = AW'(cur_q.position);
	assign empty    = !out_valid_q;
	assign rsp      = out_q;

	always_comb begin
		start_rsp = RSP_ZERO;
		start_rsp.count_out = 7'(count_q);
		case (job.op) inside
			OP_INS_FRONT, OP_INS_BACK: begin
				if (is_full) begin
					start_rsp.status = ST_FULL;
				end else begin
					start_rsp.count_out = 7'(count_q + 1'b1);
				end
			end
			OP_REM_FRONT, OP_REM_BACK: begin
				if (is_empty) begin
					start_rsp.status = ST_EMPTY;
				end
			end
			OP_REM_AT: begin
				if (bad_pos) begin
					start_rsp.status = ST_BADPOS;
				end
			end
			OP_SEARCH: begin
				if (is_empty) begin
					start_rsp.status      = ST_NOTFOUND;
					start_rsp.found_value = -32'sd1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rd_lidx = idx_q;
		case (state_q)
			S_IDLE: begin
				case (job.op)
					OP_REM_BACK: rd_lidx = AW'(count_q - 1'b1);
					OP_REM_AT:   rd_lidx = AW'(job.position);
					default:     rd_lidx = '0;
				endcase
			end
			S_SEARCH, S_SHRD: rd_lidx = idx_q + 1'b1;
			default:          rd_lidx = idx_q;
		endcase
		rd_addr = phys(head_q, rd_lidx);
	end

	always_comb begin
		we = 1'b0;
		wa = phys(head_q, idx_q);
		wd = rd_data_q;
		if (start && !is_full && job.op == OP_INS_FRONT) begin
			we = 1'b1;
			wa = head_dec;
			wd = {job.key, job.value};
		end else if (start && !is_full && job.op == OP_INS_BACK) begin
			we = 1'b1;
			wa = phys(head_q, AW'(count_q));
			wd = {job.key, job.value};
		end else if (state_q == S_SHWR) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_data_q <= mem_q[rd_addr];
		if (xfer) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cur_q <= job;
						res_q <= start_rsp;
						case (job.op) inside
							OP_INS_FRONT, OP_INS_BACK: begin
								res_valid_q <= 1'b1;
								if (!is_full) begin
									count_q <= count_q + 1'b1;
									if (job.op == OP_INS_FRONT) begin
										head_q <= head_dec;
									end
								end
							end
							OP_REM_FRONT, OP_REM_BACK: begin
								if (is_empty) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= S_RDWAIT;
								end
							end
							OP_REM_AT: begin
								if (bad_pos) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= S_RDWAIT;
								end
							end
							OP_SEARCH: begin
								if (is_empty) begin
									res_valid_q <= 1'b1;
								end else begin
									idx_q   <= '0;
									state_q <= S_SEARCH;
								end
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					res_q.removed_key <= rd_data_q[63:32];
					// remove at an inner position needs a shift of the tail
					if (cur_q.op == OP_REM_AT && cur_pos != '0 &&
					    CW'(cur_pos) + 1'b1 != count_q) begin
						idx_q   <= cur_pos;
						state_q <= S_SHRD;
					end else begin
						if (cur_q.op == OP_REM_FRONT ||
						    (cur_q.op == OP_REM_AT && cur_pos == '0)) begin
							head_q <= head_inc;
						end
						count_q         <= count_q - 1'b1;
						res_q.count_out <= 7'(count_q - 1'b1);
						res_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					idx_q <= idx_q + 1'b1;
					if (CW'(idx_q) + CW'(2) < count_q) begin
						state_q <= S_SHRD;
					end else begin
						count_q         <= count_q - 1'b1;
						res_q.count_out <= 7'(count_q - 1'b1);
						res_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_SEARCH: begin
					if (rd_data_q[63:32] == cur_q.key) begin
						res_q.found_index <= 6'(idx_q);
						res_q.found_value <= rd_data_q[31:0];
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end else if (CW'(idx_q) + 1'b1 == count_q) begin
						res_q.status      <= ST_NOTFOUND;
						res_q.found_value <= -32'sd1;
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/ordered_key_value_list_top.sv
`default_nettype none
// Path from the front queue head: insert, a failed command or an unused code is
// settled on acceptance; remove front/back reads in S_RDWAIT; search walks in
// S_SEARCH to the match or the end; remove at an inner position shifts the tail
// through S_SHRD and S_SHWR. One item in the back engine at a time; the memory's
// registered read sets the walk. An output register lets one result wait without
// stalling the engine. Reset empties list and queues, memory not cleared.
// ----------------------------------------------------------------------------
// ordered_key_value_list_top
// Bounded ordered key/value list with front/back insert, remove and search.
// ----------------------------------------------------------------------------
module ordered_key_value_list_top import okvl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      empty,
	input  wire logic pop,
	output rsp_t      rsp
);

	logic job_valid;
	job_t job;
	logic take;

	okvl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.job_valid (job_valid),
		.job       (job),
		.take      (take)
	);

	okvl_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.take      (take),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == ST_FULL) |-> rsp.count_out == 7'(DEPTH))
		else $error("full status with count below depth");
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == ST_EMPTY) |-> rsp.count_out == 7'd0)
		else $error("empty status with nonzero count");
	a_notfound_val: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == ST_NOTFOUND) |->
		(rsp.found_value == -32'sd1 && rsp.found_index == 6'd0))
		else $error("failed search fields wrong");
	a_badpos_key: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == ST_BADPOS) |-> rsp.removed_key == 32'sd0)
		else $error("bad position reports a removed key");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered key/value list.
// Drives insert/remove/search commands through the request queue, predicts
// every response from a local model of the list and compares field by field.
// ----------------------------------------------------------------------------
module tb import okvl_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int RAND_ITEMS = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	req_t req = '0;
	rsp_t rsp;

	ordered_key_value_list_top #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// list model
	logic [31:0] list_keys[$];
	logic [31:0] list_vals[$];
	rsp_t pending_rsp[$];
	int errors = 0;
	int n_ok = 0, n_err = 0, n_rsp = 0;
	bit hold_rx = 1'b0;
	bit no_idle = 1'b0;
	bit stim_done = 1'b0;

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int i;
		o = RSP_ZERO;
		case (r.cmd)
			CMD_INS_FRONT, CMD_INS_BACK: begin
				if (list_keys.size() >= LIST_DEPTH) begin
					o.status = ST_FULL;
				end else if (r.cmd == CMD_INS_FRONT) begin
					list_keys.push_front(r.key_in);
					list_vals.push_front(r.value_in);
				end else begin
					list_keys.push_back(r.key_in);
					list_vals.push_back(r.value_in);
				end
			end
			CMD_REM_FRONT, CMD_REM_BACK: begin
				if (list_keys.size() == 0) begin
					o.status = ST_EMPTY;
				end else if (r.cmd == CMD_REM_FRONT) begin
					o.removed_key = list_keys.pop_front();
					void'(list_vals.pop_front());
				end else begin
					o.removed_key = list_keys.pop_back();
					void'(list_vals.pop_back());
				end
			end
			CMD_REM_AT: begin
				if (r.position >= list_keys.size()) begin
					o.status = ST_BADPOS;
				end else begin
					o.removed_key = list_keys[r.position];
					list_keys.delete(r.position);
					list_vals.delete(r.position);
				end
			end
			CMD_SEARCH: begin
				o.status = ST_NOTFOUND;
				o.found_value = -32'sd1;
				for (i = 0; i < list_keys.size(); i++) begin
					if (list_keys[i] == r.key_in) begin
						o.status = ST_OK;
						o.found_index = i[5:0];
						o.found_value = list_vals[i];
						break;
					end
				end
			end
			default: ;
		endcase
		o.count_out = 7'(list_keys.size());
		if (o.status == ST_OK) n_ok++; else n_err++;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (response %0d)", what, got, want, n_rsp);
		errors++;
	endtask

	task automatic wait_gap();
		int n;
		n = $urandom_range(1, 19);
		repeat (n) @(posedge clk);
	endtask

	// one stimulus row; want_valid marks a hand-typed expectation
	typedef struct {
		req_t r;
		bit   want_valid;
		rsp_t want;
	} row_t;

	// leaves push high after the accepting edge; the caller drops it
	task automatic send_item(req_t r);
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_row(row_t row);
		rsp_t p;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			wait_gap();
		end
		p = list_apply(row.r);
		if (row.want_valid && p != row.want) begin
			$display("directed row disagrees with model: cmd %0d", row.r.cmd);
			errors++;
		end
		pending_rsp.push_back(p);
		send_item(row.r);
	endtask

	function automatic req_t mk(logic [2:0] c, logic [31:0] k, logic [31:0] v,
			logic [5:0] p);
		req_t r;
		r.cmd = c; r.key_in = k; r.value_in = v; r.position = p;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(status_t s, logic [31:0] rk, logic [5:0] fi,
			logic [31:0] fv, logic [6:0] cnt);
		rsp_t o;
		o.status = s; o.removed_key = rk; o.found_index = fi;
		o.found_value = fv; o.count_out = cnt;
		return o;
	endfunction

	function automatic req_t rand_req(logic [31:0] key_pool[$]);
		req_t r;
		int u;
		r.key_in = $urandom();
		r.value_in = $urandom();
		r.position = $urandom_range(0, 63);
		u = $urandom_range(0, 99);
		// insert-heavy when short, remove-heavy when long
		if (u < 30) r.cmd = (list_keys.size() < 40) ? CMD_INS_BACK : CMD_REM_FRONT;
		else if (u < 50) r.cmd = (list_keys.size() < 40) ? CMD_INS_FRONT : CMD_REM_BACK;
		else if (u < 60) r.cmd = CMD_REM_FRONT;
		else if (u < 68) r.cmd = CMD_REM_BACK;
		else if (u < 80) r.cmd = CMD_REM_AT;
		else if (u < 98) r.cmd = CMD_SEARCH;
		else r.cmd = 3'($urandom_range(6, 7));
		if (r.cmd == CMD_REM_AT && list_keys.size() > 0 && $urandom_range(0, 3) != 0)
			r.position = 6'($urandom_range(0, list_keys.size() - 1));
		if (r.cmd == CMD_SEARCH && list_keys.size() > 0 && $urandom_range(0, 2) != 0)
			r.key_in = list_keys[$urandom_range(0, list_keys.size() - 1)];
		if ($urandom_range(0, 9) == 0) r.key_in = key_pool[$urandom_range(0, 3)];
		return r;
	endfunction

	// response side
	initial begin : rx
		int n;
		rsp_t w;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				n_rsp++;
				if (pending_rsp.size() == 0) begin
					$display("unexpected response, status %0d", rsp.status);
					errors++;
				end else begin
					w = pending_rsp.pop_front();
					if (rsp.status != w.status)
						report_mismatch("status", 32'(rsp.status), 32'(w.status));
					if (rsp.removed_key != w.removed_key)
						report_mismatch("removed_key", rsp.removed_key, w.removed_key);
					if (rsp.found_index != w.found_index)
						report_mismatch("found_index", 32'(rsp.found_index),
							32'(w.found_index));
					if (rsp.found_value != w.found_value)
						report_mismatch("found_value", rsp.found_value, w.found_value);
					if (rsp.count_out != w.count_out)
						report_mismatch("count_out", 32'(rsp.count_out), 32'(w.count_out));
				end
			end
			if (hold_rx) begin
				pop <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				pop <= 1'b0;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// long receiver stall so the request queue backs up
	initial begin : stall
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_rx = 1'b1;
		repeat (2000) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin : tx
		row_t rows[$];
		row_t row;
		logic [31:0] key_pool[$];
		int i;
		key_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list errors, extremes, every command
		rows.push_back('{mk(CMD_REM_FRONT, 0, 0, 0), 1,
			mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
		rows.push_back('{mk(CMD_REM_BACK, 0, 0, 0), 1,
			mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
		rows.push_back('{mk(CMD_REM_AT, 0, 0, 0), 1,
			mk_rsp(ST_BADPOS, 0, 0, 0, 0)});
		rows.push_back('{mk(CMD_SEARCH, 0, 0, 0), 1,
			mk_rsp(ST_NOTFOUND, 0, 0, 32'hffff_ffff, 0)});
		rows.push_back('{mk(3'd6, 32'hffff_ffff, 32'hffff_ffff, 6'h3f), 1,
			mk_rsp(ST_OK, 0, 0, 0, 0)});
		rows.push_back('{mk(CMD_INS_FRONT, 32'h8000_0000, 32'h7fff_ffff, 6'h3f), 1,
			mk_rsp(ST_OK, 0, 0, 0, 1)});
		rows.push_back('{mk(CMD_INS_BACK, 32'h7fff_ffff, 32'h8000_0000, 0), 1,
			mk_rsp(ST_OK, 0, 0, 0, 2)});
		rows.push_back('{mk(CMD_INS_FRONT, 32'hffff_ffff, 32'h0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_INS_BACK, 32'hffff_ffff, 32'h5555_aaaa, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_SEARCH, 32'hffff_ffff, 0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_SEARCH, 32'h7fff_ffff, 0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_SEARCH, 32'h1234_5678, 0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_REM_AT, 0, 0, 6'h3f), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_REM_AT, 0, 0, 6'd1), 0, RSP_ZERO});
		rows.push_back('{mk(3'd7, 0, 0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_REM_BACK, 0, 0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_REM_FRONT, 0, 0, 0), 0, RSP_ZERO});
		rows.push_back('{mk(CMD_REM_FRONT, 0, 0, 0), 0, RSP_ZERO});
		foreach (rows[j]) send_row(rows[j]);

		// fill to capacity, overflow, search the tail, remove the last slot and the first
		for (i = 0; i < LIST_DEPTH + 2; i++) begin
			row.r = mk(i[0] ? CMD_INS_FRONT : CMD_INS_BACK, $urandom(), $urandom(), 0);
			row.want_valid = 0;
			send_row(row);
		end
		row.r = mk(CMD_SEARCH, list_keys[LIST_DEPTH - 1], 0, 0);
		send_row(row);
		row.r = mk(CMD_REM_AT, 0, 0, 6'(LIST_DEPTH - 1));
		send_row(row);
		row.r = mk(CMD_REM_AT, 0, 0, 6'd0);
		send_row(row);

		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS - 150) no_idle = 1'b1;
			row.r = rand_req(key_pool);
			send_row(row);
		end
		push <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin : finish_ctl
		wait (stim_done);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("tb: %0d responses checked, %0d ok and %0d error statuses,",
			n_rsp, n_ok, n_err);
		$display("tb: covered full/empty lists, bad positions, misses and stalls");
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("timeout");
		$display("tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

### ordered_key_value_list_top.f
hdl/okvl_pkg.sv
hdl/okvl_front.sv
hdl/okvl_back.sv
hdl/ordered_key_value_list_top.sv
tb/tb.sv
